// ----- rtl/core/hps_pkg.sv -----
// Shared types and constants for the haptic pattern sequencer.
// No dependencies; imported by every module of the block.
package hps_pkg;

    // Command word opcodes
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    // Patterns 0..6 exist; pattern 7 is refused
    localparam logic [2:0] NUM_PATTERNS = 3'd7;

    typedef struct packed {
        logic [1:0] opcode;
        logic [2:0] pattern_number;
        logic       power_running;
    } hps_cmd_t;

    typedef struct packed {
        logic motor_drive;
        logic busy_playing;
        logic start_taken;
    } hps_rsp_t;

    // One pattern ROM entry as seen by the player
    typedef struct packed {
        logic [7:0] dur_ms;
        logic       off;
        logic [2:0] len;
    } hps_entry_t;

endpackage

// ----- rtl/core/hps_rom.sv -----
// Built-in vibration pattern ROM: phase duration, off flag, pattern length.
// Depends on hps_pkg.
module hps_rom (
    input  logic [2:0]         pattern,
    input  logic [2:0]         pos,
    output hps_pkg::hps_entry_t entry
);
    import hps_pkg::*;

    // Pattern length and per-entry duration / off flag
    always_comb
    begin
        entry.dur_ms = 8'd0;
        entry.off    = 1'b0;
        entry.len    = 3'd0;
        case (pattern)
            3'd0:
            begin
                entry.len = 3'd1;
                if (pos == 3'd0) entry.dur_ms = 8'd20;
            end
            3'd1:
            begin
                entry.len = 3'd1;
                if (pos == 3'd0) entry.dur_ms = 8'd40;
            end
            3'd2:
            begin
                entry.len = 3'd1;
                if (pos == 3'd0) entry.dur_ms = 8'd80;
            end
            3'd3:
            begin
                entry.len = 3'd3;
                case (pos)
                    3'd0: entry.dur_ms = 8'd30;
                    3'd1:
                    begin
                        entry.dur_ms = 8'd80;
                        entry.off    = 1'b1;
                    end
                    3'd2: entry.dur_ms = 8'd15;
                    default: entry.dur_ms = 8'd0;
                endcase
            end
            3'd4:
            begin
                entry.len = 3'd3;
                case (pos)
                    3'd0: entry.dur_ms = 8'd50;
                    3'd1:
                    begin
                        entry.dur_ms = 8'd100;
                        entry.off    = 1'b1;
                    end
                    3'd2: entry.dur_ms = 8'd50;
                    default: entry.dur_ms = 8'd0;
                endcase
            end
            3'd5:
            begin
                entry.len = 3'd5;
                case (pos)
                    3'd0, 3'd2, 3'd4: entry.dur_ms = 8'd50;
                    3'd1, 3'd3:
                    begin
                        entry.dur_ms = 8'd100;
                        entry.off    = 1'b1;
                    end
                    default: entry.dur_ms = 8'd0;
                endcase
            end
            3'd6:
            begin
                entry.len = 3'd5;
                case (pos)
                    3'd0, 3'd2, 3'd4: entry.dur_ms = 8'd100;
                    3'd1, 3'd3:
                    begin
                        entry.dur_ms = 8'd200;
                        entry.off    = 1'b1;
                    end
                    default: entry.dur_ms = 8'd0;
                endcase
            end
            default:
            begin
                entry.len = 3'd0;
            end
        endcase
    end

endmodule

// ----- rtl/core/hps_core.sv -----
// Player state and next-state logic: countdown, entry load, start and stop.
// Depends on hps_pkg and hps_rom.
module hps_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  hps_pkg::hps_cmd_t cmd,
    output hps_pkg::hps_rsp_t rsp
);
    import hps_pkg::*;

    logic [2:0] cur_pattern_reg,  cur_pattern_next;
    logic [2:0] entry_pos_reg,    entry_pos_next;
    logic [7:0] phase_ms_reg,     phase_ms_next;
    logic       motor_reg,        motor_next;
    logic       entries_left_reg, entries_left_next;

    logic [2:0] rom_pattern;
    logic [2:0] rom_pos;
    logic       load_left;
    hps_entry_t entry;
    logic [7:0] phase_dec;
    logic       busy_now;
    logic       start_ok;
    logic [3:0] pos_inc;

    hps_rom u_rom (
        .pattern (rom_pattern),
        .pos     (rom_pos),
        .entry   (entry)
    );

    assign busy_now  = entries_left_reg | motor_reg;
    assign phase_dec = phase_ms_reg - 8'd1;
    assign start_ok  = cmd.power_running && !busy_now && (cmd.pattern_number < NUM_PATTERNS);

    // ROM address: a start loads entry 0 of the new pattern, a tick the next entry
    always_comb
    begin
        if (cmd.opcode == OP_START)
        begin
            rom_pattern = cmd.pattern_number;
            rom_pos     = 3'd0;
            load_left   = 1'b1;
        end
        else
        begin
            rom_pattern = cur_pattern_reg;
            rom_pos     = entry_pos_reg;
            load_left   = entries_left_reg;
        end
    end

    assign pos_inc = {1'b0, rom_pos} + 4'd1;

    // Next state
    always_comb
    begin
        cur_pattern_next  = cur_pattern_reg;
        entry_pos_next    = entry_pos_reg;
        phase_ms_next     = phase_ms_reg;
        motor_next        = motor_reg;
        entries_left_next = entries_left_reg;
        rsp.start_taken   = 1'b0;
        case (cmd.opcode)
            OP_TICK:
            begin
                if (phase_ms_reg != 8'd0)
                begin
                    phase_ms_next = phase_dec;
                    if (phase_dec == 8'd0)
                    begin
                        // phase over: load next entry or halt
                        if (!load_left || ({1'b0, rom_pos} >= {1'b0, entry.len}))
                        begin
                            entries_left_next = 1'b0;
                            entry_pos_next    = 3'd0;
                            phase_ms_next     = 8'd0;
                            motor_next        = 1'b0;
                        end
                        else
                        begin
                            motor_next        = ~entry.off;
                            phase_ms_next     = entry.dur_ms;
                            entry_pos_next    = pos_inc[2:0];
                            entries_left_next = (pos_inc < {1'b0, entry.len});
                        end
                    end
                end
            end
            OP_START:
            begin
                if (start_ok)
                begin
                    cur_pattern_next  = cmd.pattern_number;
                    motor_next        = ~entry.off;
                    phase_ms_next     = entry.dur_ms;
                    entry_pos_next    = pos_inc[2:0];
                    entries_left_next = (pos_inc < {1'b0, entry.len});
                    rsp.start_taken   = 1'b1;
                end
            end
            OP_STOP:
            begin
                entries_left_next = 1'b0;
                entry_pos_next    = 3'd0;
                phase_ms_next     = 8'd0;
                motor_next        = 1'b0;
            end
            default:
            begin
                // unused opcode: state unchanged
            end
        endcase
        rsp.motor_drive  = motor_next;
        rsp.busy_playing = entries_left_next | motor_next;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_pattern_reg  <= 3'd0;
            entry_pos_reg    <= 3'd0;
            phase_ms_reg     <= 8'd0;
            motor_reg        <= 1'b0;
            entries_left_reg <= 1'b0;
        end
        else if (step)
        begin
            cur_pattern_reg  <= cur_pattern_next;
            entry_pos_reg    <= entry_pos_next;
            phase_ms_reg     <= phase_ms_next;
            motor_reg        <= motor_next;
            entries_left_reg <= entries_left_next;
        end
    end

endmodule

// ----- rtl/core/haptic_pattern_sequencer.sv -----
// Top level of the haptic pattern sequencer: command register, player, result register.
// Depends on hps_pkg and hps_core.
//
// Takes one command word (tick, start, stop) per clock and returns one result
// word per command, in order. A command is held in the input register, where the
// player updates its state and the ROM lookup, then lands in the result register,
// from which the result word can leave. Sustained rate is one word per cycle; the
// only stall comes from the result side holding rsp_stall, which back-pressures
// through the input register.
module haptic_pattern_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  hps_pkg::hps_cmd_t cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output hps_pkg::hps_rsp_t rsp
);
    import hps_pkg::*;

    logic     cmd_valid_reg;
    hps_cmd_t cmd_reg;
    logic     rsp_valid_reg;
    hps_rsp_t rsp_reg;
    hps_rsp_t rsp_next;
    logic     out_free;
    logic     step;

    // Result register can take a word when empty or draining
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign step      = cmd_valid_reg && out_free;
    assign cmd_stall = cmd_valid_reg && !out_free;

    hps_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .cmd   (cmd_reg),
        .rsp   (rsp_next)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cmd_valid_reg <= 1'b0;
        else if (!cmd_stall)
            cmd_valid_reg <= cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
            cmd_reg <= cmd;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (out_free)
            rsp_valid_reg <= step;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- rtl/core/hps_checker.sv -----
// Port-level checks for the haptic pattern sequencer, bound to the top level.
// Depends on hps_pkg and haptic_pattern_sequencer.
module hps_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input hps_pkg::hps_cmd_t cmd,
    input logic              rsp_valid,
    input logic              rsp_stall,
    input hps_pkg::hps_rsp_t rsp
);
    import hps_pkg::*;

    // A stalled command word holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_stall |=> cmd_valid && $stable(cmd))
        else $error("command word changed while stalled");

    // A stalled result word holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("result word changed while stalled");

    // A running motor always reports busy
    a_motor_busy: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.motor_drive |-> rsp.busy_playing)
        else $error("motor on while not busy");

    // Every pattern opens with an on phase
    a_start_on: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.start_taken |-> rsp.motor_drive && rsp.busy_playing)
        else $error("accepted start without motor on");

    // Input stalls only while a result is waiting on a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> rsp_valid && rsp_stall)
        else $error("command stalled without output back-pressure");

endmodule

bind haptic_pattern_sequencer hps_checker u_hps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ----- tb/hps_player_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the haptic pattern sequencer: follows the pattern player from
// accepted command words and compares every result word, in order. Depends on hps_pkg.
module hps_player_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  logic              cmd_stall,
    input  hps_pkg::hps_cmd_t cmd,
    input  logic              rsp_valid,
    input  logic              rsp_stall,
    input  hps_pkg::hps_rsp_t rsp,
    output int                mismatches,
    output int                pending,
    output int                results_checked,
    output int                starts_taken
);
    import hps_pkg::*;

    // Player state as the block should hold it
    logic [2:0] play_pattern;
    logic [2:0] next_entry;
    logic [7:0] ms_left;
    logic       motor_on;
    logic       more_entries;

    hps_rsp_t expected_rsp_q[$];

    // Built-in patterns: odd entries of the multi-phase patterns are motor-off gaps
    function automatic hps_entry_t rom_entry(input logic [2:0] pat, input logic [2:0] idx);
        hps_entry_t e;
        e = '0;
        case (pat)
            3'd0: begin e.len = 3'd1; e.dur_ms = 8'd20; end
            3'd1: begin e.len = 3'd1; e.dur_ms = 8'd40; end
            3'd2: begin e.len = 3'd1; e.dur_ms = 8'd80; end
            3'd3:
            begin
                e.len    = 3'd3;
                e.off    = (idx == 3'd1);
                e.dur_ms = (idx == 3'd0) ? 8'd30 : ((idx == 3'd1) ? 8'd80 : 8'd15);
            end
            3'd4:
            begin
                e.len    = 3'd3;
                e.off    = (idx == 3'd1);
                e.dur_ms = e.off ? 8'd100 : 8'd50;
            end
            3'd5:
            begin
                e.len    = 3'd5;
                e.off    = idx[0];
                e.dur_ms = e.off ? 8'd100 : 8'd50;
            end
            3'd6:
            begin
                e.len    = 3'd5;
                e.off    = idx[0];
                e.dur_ms = e.off ? 8'd200 : 8'd100;
            end
            default: ;
        endcase
        return e;
    endfunction

    task automatic clear_player();
        more_entries = 1'b0;
        next_entry   = '0;
        ms_left      = '0;
        motor_on     = 1'b0;
    endtask

    // Load the next phase, or stop with the motor off once the pattern is used up
    task automatic load_next_entry();
        hps_entry_t e;
        e = rom_entry(play_pattern, next_entry);
        if (play_pattern >= NUM_PATTERNS || !more_entries || next_entry >= e.len)
            clear_player();
        else
        begin
            motor_on     = !e.off;
            ms_left      = e.dur_ms;
            next_entry   = next_entry + 3'd1;
            more_entries = (next_entry < e.len);
        end
    endtask

    // One command word in, one expected result word out
    task automatic apply_command(input hps_cmd_t c, output hps_rsp_t r);
        logic taken;
        taken = 1'b0;
        case (c.opcode)
            OP_TICK:
                if (ms_left != 8'd0)
                begin
                    ms_left = ms_left - 8'd1;
                    if (ms_left == 8'd0)
                        load_next_entry();
                end
            OP_START:
                if (c.power_running && !(more_entries || motor_on)
                    && c.pattern_number < NUM_PATTERNS)
                begin
                    play_pattern = c.pattern_number;
                    next_entry   = '0;
                    more_entries = 1'b1;
                    load_next_entry();
                    taken        = 1'b1;
                end
            OP_STOP:
                clear_player();
            default: ;  // unused opcode: state untouched
        endcase
        r.motor_drive  = motor_on;
        r.busy_playing = more_entries || motor_on;
        r.start_taken  = taken;
    endtask

    // Watch both channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        hps_rsp_t want;
        if (!rst_n)
        begin
            play_pattern = '0;
            clear_player();
            expected_rsp_q.delete();
            mismatches      = 0;
            pending         = 0;
            results_checked = 0;
            starts_taken    = 0;
        end
        else
        begin
            // result side first; a word leaving now was predicted when its command was accepted
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: result word with nothing outstanding: ",
                                  "motor=%0b busy=%0b taken=%0b"},
                                 $realtime, rsp.motor_drive, rsp.busy_playing,
                                 rsp.start_taken);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.motor_drive !== want.motor_drive
                        || rsp.busy_playing !== want.busy_playing
                        || rsp.start_taken !== want.start_taken)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result %0d exp motor=%0b busy=%0b taken=%0b, ",
                                      "got motor=%0b busy=%0b taken=%0b"},
                                     $realtime, results_checked, want.motor_drive,
                                     want.busy_playing, want.start_taken, rsp.motor_drive,
                                     rsp.busy_playing, rsp.start_taken);
                    end
                    results_checked++;
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                apply_command(cmd, want);
                if (want.start_taken)
                    starts_taken++;
                expected_rsp_q.push_back(want);
            end
            pending = expected_rsp_q.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the haptic pattern sequencer: clock, reset, command words and
// result-side stalls. Depends on hps_pkg, haptic_pattern_sequencer and hps_player_checker.
module tb;
    import hps_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [2:0] NO_PATTERN  = 3'd7;
    localparam int         LONG_HOLD   = 300;
    localparam int         STUCK_LIMIT = 3000;
    localparam int         PHASE_WORDS = 300;

    logic     clk = 1'b0;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_stall;
    hps_cmd_t cmd;
    logic     rsp_valid;
    logic     rsp_stall;
    hps_rsp_t rsp;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    bit hold_req      = 1'b0;
    int words_sent    = 0;
    int stuck_cycles  = 0;

    int mismatches;
    int pending;
    int results_checked;
    int starts_taken;

    always #2 clk = ~clk;

    haptic_pattern_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    hps_player_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .cmd             (cmd),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked),
        .starts_taken    (starts_taken)
    );

    function automatic hps_cmd_t make_cmd(input logic [1:0] op, input logic [2:0] pn,
                                          input logic pw);
        hps_cmd_t c;
        c.opcode         = op;
        c.pattern_number = pn;
        c.power_running  = pw;
        return c;
    endfunction

    // Ticks carry random don't-care fields so every bit toggles
    function automatic hps_cmd_t random_tick();
        return make_cmd(OP_TICK, 3'($urandom_range(7)), 1'($urandom_range(1)));
    endfunction

    // Total play time of each pattern in ticks
    function automatic int pattern_ms(input logic [2:0] p);
        case (p)
            3'd0:    return 20;
            3'd1:    return 40;
            3'd2:    return 80;
            3'd3:    return 125;
            3'd4:    return 200;
            3'd5:    return 350;
            default: return 700;
        endcase
    endfunction

    // Mostly short patterns; the long ones are rare
    function automatic logic [2:0] pick_pattern();
        int r;
        r = $urandom_range(99);
        if (r < 30)      return 3'd0;
        else if (r < 55) return 3'd1;
        else if (r < 70) return 3'd2;
        else if (r < 90) return 3'd3;
        else if (r < 96) return 3'd4;
        else if (r < 99) return 3'd5;
        else             return 3'd6;
    endfunction

    // Offer one word after a random gap and hold it until accepted
    task automatic send_word(input hps_cmd_t c, input bit counted);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        if (counted)
            words_sent++;
    endtask

    // Stop sending until every result word is back
    task automatic drain();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Start a pattern and tick it through, with occasional stray commands mixed in
    task automatic play_pattern(input logic [2:0] p, input bit may_abort);
        int ticks;
        int k;
        send_word(make_cmd(OP_START, p, 1'b1), 1'b1);
        ticks = pattern_ms(p) + $urandom_range(3);
        for (int i = 0; i < ticks; i++)
        begin
            if ($urandom_range(99) < 3)
            begin
                k = $urandom_range(2);
                if (k == 2 && may_abort)
                begin
                    send_word(make_cmd(OP_STOP, 3'($urandom_range(7)),
                                       1'($urandom_range(1))), 1'b1);
                    return;
                end
                else if (k == 1)
                    send_word(make_cmd(OP_START, 3'($urandom_range(7)),
                                       1'($urandom_range(1))), 1'b0);
                else
                    send_word(make_cmd(OP_UNUSED, 3'($urandom_range(7)),
                                       1'($urandom_range(1))), 1'b0);
            end
            send_word(random_tick(), 1'b1);
        end
    endtask

    // One idling mix: chosen patterns played in full, then random sequences and noise
    task automatic run_phase(input int idle, input int stall, input logic [6:0] full_play);
        int first_word;
        send_idle_pct = idle;
        stall_pct     = stall;
        first_word    = words_sent;
        for (int p = 0; p < 7; p++)
            if (full_play[p])
                play_pattern(p[2:0], 1'b0);
        while (words_sent - first_word < PHASE_WORDS)
        begin
            if ($urandom_range(99) < 8)
                send_word(make_cmd(2'($urandom_range(3)), 3'($urandom_range(7)),
                                   1'($urandom_range(1))), 1'b1);
            else
                play_pattern(pick_pattern(), 1'b1);
        end
        drain();
    endtask

    // Result side: random stalls, plus one long hold counted here
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
                rsp_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Watchdog: ends the run when no word moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles <= 0;
        else if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("watchdog: no word moved for %0d cycles", STUCK_LIMIT);
            $display("Mismatches found");
            $finish;
        end
        else
            stuck_cycles <= stuck_cycles + 1;
    end

    initial
    begin
        rst_n     <= 1'b0;
        cmd_valid <= 1'b0;
        cmd       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle commands, refused starts, stop without power, every pattern
        send_word(make_cmd(OP_TICK, NO_PATTERN, 1'b1), 1'b1);
        send_word(make_cmd(OP_STOP, 3'd0, 1'b0), 1'b1);
        send_word(make_cmd(OP_UNUSED, 3'd5, 1'b1), 1'b1);
        send_word(make_cmd(OP_START, NO_PATTERN, 1'b1), 1'b1);
        send_word(make_cmd(OP_START, 3'd0, 1'b0), 1'b1);
        send_word(make_cmd(OP_START, 3'd0, 1'b1), 1'b1);
        send_word(make_cmd(OP_START, 3'd3, 1'b1), 1'b1);
        send_word(make_cmd(OP_TICK, 3'd2, 1'b0), 1'b1);
        send_word(make_cmd(OP_STOP, 3'd0, 1'b0), 1'b1);
        send_word(make_cmd(OP_START, 3'd6, 1'b1), 1'b1);
        send_word(make_cmd(OP_TICK, 3'd6, 1'b1), 1'b1);
        send_word(make_cmd(OP_UNUSED, 3'd0, 1'b0), 1'b1);
        send_word(make_cmd(OP_STOP, NO_PATTERN, 1'b1), 1'b1);
        for (int p = 1; p <= 5; p++)
        begin
            send_word(make_cmd(OP_START, p[2:0], 1'b1), 1'b1);
            send_word(make_cmd(OP_STOP, p[2:0], 1'b1), 1'b1);
        end
        drain();

        // Back-to-back words against a long result hold, so the input backs up
        hold_req = 1'b1;
        run_phase(0, 0, 7'b0001111);
        run_phase(87, 0, 7'b0110000);
        run_phase(0, 87, 7'b0000000);
        run_phase(24, 24, 7'b1000000);

        repeat (8) @(posedge clk);
        $display("Run covered %0d command words over four gap and stall mixes,", words_sent);
        $display("each pattern played to its end; %0d results checked, %0d starts taken",
                 results_checked, starts_taken);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
